### hw/rtl/pcb_pkg.sv
// Shared types and constants for the periodic cell binning pipeline.
// No dependencies; imported by pcb_axis, pcb_index and periodic_cell_binning.
`default_nettype none

package pcb_pkg;

    localparam int POS_W      = 32;  // signed Q16.16 position
    localparam int LEN_W      = 31;  // unsigned Q15.16 box length
    localparam int INV_W      = 32;  // unsigned Q16.16 reciprocal cell size
    localparam int CELL_W     = 24;  // linear cell index / grid_dims width
    localparam int PROD_SHIFT = 32;  // Q16.16 * Q16.16 -> integer part
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID  = 3'd6;

    // Reset values: lengths 1.0, reciprocals 1.0, grid 3 x 3 x 3
    localparam logic [LEN_W-1:0]  LEN_RST  = 31'd65536;
    localparam logic [INV_W-1:0]  INV_RST  = 32'd65536;
    localparam logic [CELL_W-1:0] GRID_RST = 24'd197379;

    // Per-stage advance strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos3;

endpackage

`default_nettype wire

### hw/rtl/pcb_axis.sv
// One axis: periodic position wrap, Q16.16 multiply with floor, cell coordinate wrap.
// Stages s1..s3 of the pipeline; depends on pcb_pkg.
`default_nettype none

module pcb_axis
    import pcb_pkg::*;
#(
    parameter int DIM_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire t_pipe_en                   i_en,
    input  wire logic signed [POS_W-1:0]    i_pos,
    input  wire logic        [LEN_W-1:0]    i_len,
    input  wire logic        [INV_W-1:0]    i_inv,
    input  wire logic        [DIM_BITS-1:0] i_n,
    output logic signed      [POS_W-1:0]    o_wrapped,
    output logic             [DIM_BITS-1:0] o_coord,
    output logic                            o_oor
);

    localparam int CW = POS_W + 2;

    // s1: wrap once into [0, length)
    logic signed [POS_W:0]   pos_e;
    logic signed [POS_W:0]   len_e;
    logic signed [POS_W:0]   n_wrap;
    logic signed [POS_W-1:0] r_wrap;

    always_comb begin
        pos_e = {i_pos[POS_W-1], i_pos};
        len_e = {2'b00, i_len};
        if (i_pos[POS_W-1]) begin
            n_wrap = pos_e + len_e;
        end else if (pos_e >= len_e) begin
            n_wrap = pos_e - len_e;
        end else begin
            n_wrap = pos_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_wrap <= n_wrap[POS_W-1:0];
        end
    end

    assign o_wrapped = r_wrap;

    // s2: exact product, floor = arithmetic shift of the integer part
    logic signed [POS_W:0]         wp_e;
    logic signed [INV_W:0]         inv_e;
    logic signed [POS_W+INV_W+1:0] prod;
    logic signed [POS_W-1:0]       r_floor;

    always_comb begin
        wp_e  = {r_wrap[POS_W-1], r_wrap};
        inv_e = {1'b0, i_inv};
        prod  = wp_e * inv_e;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_floor <= prod[PROD_SHIFT+POS_W-1:PROD_SHIFT];
        end
    end

    // s3: +1 for the halo, one periodic wrap by n, range check
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] n_e;
    logic signed [CW-1:0] c_plus;
    logic signed [CW-1:0] c_minus;
    logic signed [CW-1:0] n_coord;
    logic                 n_oor;
    logic [DIM_BITS-1:0]  r_coord;
    logic                 r_oor;

    always_comb begin
        c1      = {{2{r_floor[POS_W-1]}}, r_floor} + {{(CW-1){1'b0}}, 1'b1};
        n_e     = {{(CW-DIM_BITS){1'b0}}, i_n};
        c_plus  = c1 + n_e;
        c_minus = c1 - n_e;
        if (c1[CW-1]) begin
            n_coord = c_plus;
        end else if (c1 >= n_e) begin
            n_coord = c_minus;
        end else begin
            n_coord = c1;
        end
        n_oor = n_coord[CW-1] || (n_coord >= n_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_coord <= n_coord[DIM_BITS-1:0];
            r_oor   <= n_oor;
        end
    end

    assign o_coord = r_coord;
    assign o_oor   = r_oor;

endmodule

`default_nettype wire

### hw/rtl/pcb_index.sv
// Linear cell index (ny*cz + cy)*nx + cx over two multiply-add stages.
// Stages s4..s5 of the pipeline; depends on pcb_pkg.
`default_nettype none

module pcb_index
    import pcb_pkg::*;
#(
    parameter int DIM_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire t_pipe_en            i_en,
    input  wire logic [DIM_BITS-1:0] i_cx,
    input  wire logic [DIM_BITS-1:0] i_cy,
    input  wire logic [DIM_BITS-1:0] i_cz,
    input  wire logic [DIM_BITS-1:0] i_nx,
    input  wire logic [DIM_BITS-1:0] i_ny,
    input  wire logic                i_oor,
    output logic      [CELL_W-1:0]   o_idx,
    output logic                     o_oor
);

    localparam int PW = 2 * DIM_BITS;
    localparam int IW = 3 * DIM_BITS;

    logic [PW-1:0]       n_part;
    logic [PW-1:0]       r_part;
    logic [DIM_BITS-1:0] r_cx;
    logic                r_oor4;
    logic [IW-1:0]       n_full;
    logic [CELL_W-1:0]   r_idx;
    logic                r_oor5;

    // s4: plane row offset
    assign n_part = PW'(i_ny) * PW'(i_cz) + PW'(i_cy);

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_part <= n_part;
            r_cx   <= i_cx;
            r_oor4 <= i_oor;
        end
    end

    // s5: full index, kept to the field width
    assign n_full = IW'(r_part) * IW'(i_nx) + IW'(r_cx);

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_idx  <= CELL_W'(n_full);
            r_oor5 <= r_oor4;
        end
    end

    assign o_idx = r_idx;
    assign o_oor = r_oor5;

endmodule

`default_nettype wire

### hw/rtl/periodic_cell_binning.sv
// Top level: periodic cell binning pipeline with config registers and output stage.
// Depends on pcb_pkg, pcb_axis and pcb_index.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one particle request: position
//    pos_x/y/z in signed Q16.16 and the cell index that holds it now.
//  - Output channel (o_out_valid / i_out_ready) returns one result per request:
//    wrapped position, destination cell, moved flag and out-of-range flag.
//  - Six pipeline registers (three per-axis stages, two index stages, output
//    register) lie between a taken request and its presented result.
//  - Throughput is one request per cycle while i_out_ready stays high; the longest
//    stage is the 33x33 signed multiply of wrapped position by reciprocal cell size.
//  - Each stage advances when it is empty or the stage after it advances, so
//    bubbles close up while the receiver stalls; o_in_ready drops only when all
//    six registers hold requests and i_out_ready is low. Nothing is lost or repeated.
//  - Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and are
//    expected only while the pipeline is empty. Indexes past grid_dims are ignored.
//  - Synchronous reset empties the pipeline and loads lengths 1.0, reciprocals 1.0
//    and a 3 x 3 x 3 grid.
`default_nettype none

module periodic_cell_binning
    import pcb_pkg::*;
#(
    parameter int DIM_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    input  wire logic [CELL_W-1:0]       i_current_cell,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [POS_W-1:0]      o_wrapped_x,
    output logic signed [POS_W-1:0]      o_wrapped_y,
    output logic signed [POS_W-1:0]      o_wrapped_z,
    output logic [CELL_W-1:0]            o_target_cell,
    output logic                         o_moved,
    output logic                         o_out_of_range
);

    // grid_dims may be narrower than three dimension fields; upper fields read zero
    localparam int GW = (3 * DIM_BITS > CELL_W) ? 3 * DIM_BITS : CELL_W;

    // ---------------- config registers ----------------
    logic [LEN_W-1:0]  r_len_x, r_len_y, r_len_z;
    logic [INV_W-1:0]  r_inv_x, r_inv_y, r_inv_z;
    logic [CELL_W-1:0] r_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_x <= LEN_RST;
            r_len_y <= LEN_RST;
            r_len_z <= LEN_RST;
            r_inv_x <= INV_RST;
            r_inv_y <= INV_RST;
            r_inv_z <= INV_RST;
            r_grid  <= GRID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEN_X: begin
                    r_len_x <= i_cfg_data[LEN_W-1:0];
                end
                CFG_LEN_Y: begin
                    r_len_y <= i_cfg_data[LEN_W-1:0];
                end
                CFG_LEN_Z: begin
                    r_len_z <= i_cfg_data[LEN_W-1:0];
                end
                CFG_INV_X: begin
                    r_inv_x <= i_cfg_data[INV_W-1:0];
                end
                CFG_INV_Y: begin
                    r_inv_y <= i_cfg_data[INV_W-1:0];
                end
                CFG_INV_Z: begin
                    r_inv_z <= i_cfg_data[INV_W-1:0];
                end
                CFG_GRID: begin
                    r_grid <= i_cfg_data[CELL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic [GW-1:0]       grid_ext;
    logic [DIM_BITS-1:0] nx, ny, nz;

    assign grid_ext = GW'(r_grid);
    assign nx       = grid_ext[DIM_BITS-1:0];
    assign ny       = grid_ext[2*DIM_BITS-1:DIM_BITS];
    assign nz       = grid_ext[3*DIM_BITS-1:2*DIM_BITS];

    // ---------------- pipeline control ----------------
    // Stages 1..5 plus the output register (6). A stage loads when it is
    // empty or its successor loads.
    logic [5:1] r_v;
    logic       r_out_valid;
    logic [6:1] stage_adv;
    t_pipe_en   pipe_en;

    always_comb begin
        stage_adv[6] = !r_out_valid || i_out_ready;
        for (int k = 5; k >= 1; k--) begin
            stage_adv[k] = !r_v[k] || stage_adv[k+1];
        end
    end

    assign pipe_en.s1 = stage_adv[1];
    assign pipe_en.s2 = stage_adv[2];
    assign pipe_en.s3 = stage_adv[3];
    assign pipe_en.s4 = stage_adv[4];
    assign pipe_en.s5 = stage_adv[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (stage_adv[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= 5; k++) begin
                if (stage_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (stage_adv[6]) begin
                r_out_valid <= r_v[5];
            end
        end
    end

    assign o_in_ready  = stage_adv[1];
    assign o_out_valid = r_out_valid;

    // ---------------- per-axis datapath (stages 1-3) ----------------
    t_pos3               wpos1;
    logic [DIM_BITS-1:0] cx, cy, cz;
    logic                oor_x, oor_y, oor_z;

    pcb_axis #(.DIM_BITS(DIM_BITS)) u_axis_x (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_pos     (i_pos_x),
        .i_len     (r_len_x),
        .i_inv     (r_inv_x),
        .i_n       (nx),
        .o_wrapped (wpos1.x),
        .o_coord   (cx),
        .o_oor     (oor_x)
    );

    pcb_axis #(.DIM_BITS(DIM_BITS)) u_axis_y (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_pos     (i_pos_y),
        .i_len     (r_len_y),
        .i_inv     (r_inv_y),
        .i_n       (ny),
        .o_wrapped (wpos1.y),
        .o_coord   (cy),
        .o_oor     (oor_y)
    );

    pcb_axis #(.DIM_BITS(DIM_BITS)) u_axis_z (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_pos     (i_pos_z),
        .i_len     (r_len_z),
        .i_inv     (r_inv_z),
        .i_n       (nz),
        .o_wrapped (wpos1.z),
        .o_coord   (cz),
        .o_oor     (oor_z)
    );

    // ---------------- linear index (stages 4-5) ----------------
    logic [CELL_W-1:0] idx5;
    logic              oor5;

    pcb_index #(.DIM_BITS(DIM_BITS)) u_index (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_cx  (cx),
        .i_cy  (cy),
        .i_cz  (cz),
        .i_nx  (nx),
        .i_ny  (ny),
        .i_oor (oor_x || oor_y || oor_z),
        .o_idx (idx5),
        .o_oor (oor5)
    );

    // ---------------- side pipeline: current cell and wrapped position ----
    logic [CELL_W-1:0] r_cur  [1:5];
    t_pos3             r_wpos [2:5];

    always_ff @(posedge i_clk) begin
        if (stage_adv[1]) begin
            r_cur[1] <= i_current_cell;
        end
        if (stage_adv[2]) begin
            r_cur[2]  <= r_cur[1];
            r_wpos[2] <= wpos1;
        end
        for (int k = 3; k <= 5; k++) begin
            if (stage_adv[k]) begin
                r_cur[k]  <= r_cur[k-1];
                r_wpos[k] <= r_wpos[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    // Out of range leaves the particle where it is: dest = current, not moved.
    t_pos3             r_out_pos;
    logic [CELL_W-1:0] r_dest;
    logic              r_moved;
    logic              r_oor;

    always_ff @(posedge i_clk) begin
        if (stage_adv[6]) begin
            r_out_pos <= r_wpos[5];
            r_dest    <= oor5 ? r_cur[5] : idx5;
            r_moved   <= !oor5 && (idx5 != r_cur[5]);
            r_oor     <= oor5;
        end
    end

    assign o_wrapped_x    = r_out_pos.x;
    assign o_wrapped_y    = r_out_pos.y;
    assign o_wrapped_z    = r_out_pos.z;
    assign o_target_cell  = r_dest;
    assign o_moved        = r_moved;
    assign o_out_of_range = r_oor;

    // ---------------- assertions ----------------
    // A particle flagged out of range is never reported as moved.
    a_moved_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moved |-> !o_out_of_range)
        else $error("moved result flagged out of range");

    // Requests are refused only when every stage is occupied.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v == 5'b11111) && r_out_valid && !i_out_ready)
        else $error("input stalled with a free pipeline slot");

    // A request leaving the last stage lands in the output register.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && stage_adv[6] |=> o_out_valid)
        else $error("request dropped between stage five and the output");

endmodule

`default_nettype wire
